// ----- rtl/nwbf_pkg.sv -----
// Shared types and constants for the nearest waypoint body-frame block.
// Used by the front queue, the back-end engine and the top level.
`default_nettype none

package nwbf_pkg;

   localparam int WP_DEPTH      = 1024;
   localparam int IDX_W         = $clog2(WP_DEPTH);
   localparam int CNT_W         = IDX_W + 1;
   localparam int MAX_LOOKAHEAD = 64;
   localparam int LA_W          = 7;
   localparam int LA_RESET      = 50;
   localparam int POS_W         = 32;
   localparam int TRIG_W        = 16;
   localparam int FRAC_TRIG     = 14;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = CNT_W;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_POSE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_WAYPOINT_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOKAHEAD      = 1'b1;

   typedef struct packed {
      logic                     is_pose;
      logic [IDX_W-1:0]         wp_index;
      logic signed [POS_W-1:0]  pos_x;
      logic signed [POS_W-1:0]  pos_y;
      logic signed [TRIG_W-1:0] yaw_cos;
      logic signed [TRIG_W-1:0] yaw_sin;
   } cmd_type;

endpackage

`default_nettype wire

// ----- rtl/nearest_waypoint_body_frame.sv -----
// Top level of the nearest waypoint body-frame block: front queue and back end.
// Depends on nwbf_pkg, nwbf_front and nwbf_back.
`default_nettype none

// A load item is taken from the queue and writes one table entry. A pose
// item scans the first waypoint_count entries through a pipelined distance
// unit, one entry per cycle, then emits each lookahead waypoint through the
// read, data, multiply and output states in turn. The scan rate is set by
// the single read port of the waypoint tables, and the emit rate by the
// read, subtract, multiply and output steps that handle one waypoint at a
// time. A four-item queue keeps taking items while the back end works, and
// the result register holds a finished item while the consumer stalls.
module nearest_waypoint_body_frame import nwbf_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     req_opcode,
   input  wire logic [IDX_W-1:0]         req_wp_index,
   input  wire logic signed [POS_W-1:0]  req_pos_x,
   input  wire logic signed [POS_W-1:0]  req_pos_y,
   input  wire logic signed [TRIG_W-1:0] req_yaw_cos,
   input  wire logic signed [TRIG_W-1:0] req_yaw_sin,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [IDX_W-1:0]              rsp_point_index,
   output logic [IDX_W-1:0]              rsp_nearest_index,
   output logic signed [POS_W-1:0]       rsp_body_x,
   output logic signed [POS_W-1:0]       rsp_body_y,
   output logic                          rsp_last,
   input  wire logic                     csr_write,
   input  wire logic [CSR_IDX_W-1:0]     csr_index,
   input  wire logic [CSR_DATA_W-1:0]    csr_data
);

   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;

   nwbf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_opcode   (req_opcode),
      .req_wp_index (req_wp_index),
      .req_pos_x    (req_pos_x),
      .req_pos_y    (req_pos_y),
      .req_yaw_cos  (req_yaw_cos),
      .req_yaw_sin  (req_yaw_sin),
      .cmd_valid    (cmd_valid),
      .cmd          (cmd),
      .cmd_pop      (cmd_pop)
   );

   nwbf_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_valid         (cmd_valid),
      .cmd               (cmd),
      .cmd_pop           (cmd_pop),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_point_index   (rsp_point_index),
      .rsp_nearest_index (rsp_nearest_index),
      .rsp_body_x        (rsp_body_x),
      .rsp_body_y        (rsp_body_y),
      .rsp_last          (rsp_last)
   );

endmodule

`default_nettype wire

// ----- rtl/nwbf_front.sv -----
// Front end: accepts items, classifies them as load or pose commands and
// holds them in a short queue for the back end. Depends on nwbf_pkg.
`default_nettype none

module nwbf_front import nwbf_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     req_opcode,
   input  wire logic [IDX_W-1:0]         req_wp_index,
   input  wire logic signed [POS_W-1:0]  req_pos_x,
   input  wire logic signed [POS_W-1:0]  req_pos_y,
   input  wire logic signed [TRIG_W-1:0] req_yaw_cos,
   input  wire logic signed [TRIG_W-1:0] req_yaw_sin,
   output logic                          cmd_valid,
   output cmd_type                       cmd,
   input  wire logic                     cmd_pop
);

   cmd_type              q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QFILL_W-1:0]   fill_ff, fill_in;
   logic                 push;
   cmd_type              new_cmd;

   always_comb begin
      new_cmd.is_pose  = (req_opcode == OP_POSE);
      new_cmd.wp_index = req_wp_index;
      new_cmd.pos_x    = req_pos_x;
      new_cmd.pos_y    = req_pos_y;
      new_cmd.yaw_cos  = req_yaw_cos;
      new_cmd.yaw_sin  = req_yaw_sin;
   end

   assign req_stall = (fill_ff == QFILL_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (fill_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + QFILL_W'(push) - QFILL_W'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= QFILL_W'(QUEUE_DEPTH))
      else $error("queue fill exceeds depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> fill_ff != '0)
      else $error("queue popped while empty");

   a_fill_track: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> fill_ff ==
         $past(fill_ff) + QFILL_W'($past(push)) - QFILL_W'($past(cmd_pop)))
      else $error("queue fill out of step with pushes and pops");

endmodule

`default_nettype wire

// ----- rtl/nwbf_back.sv -----
// Back end: waypoint tables, nearest-point scan pipeline, body-frame rotation
// and the result register. Depends on nwbf_pkg.
`default_nettype none

module nwbf_back import nwbf_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     cmd_valid,
   input  wire cmd_type                  cmd,
   output logic                          cmd_pop,
   input  wire logic                     csr_write,
   input  wire logic [CSR_IDX_W-1:0]     csr_index,
   input  wire logic [CSR_DATA_W-1:0]    csr_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [IDX_W-1:0]              rsp_point_index,
   output logic [IDX_W-1:0]              rsp_nearest_index,
   output logic signed [POS_W-1:0]       rsp_body_x,
   output logic signed [POS_W-1:0]       rsp_body_y,
   output logic                          rsp_last
);

   localparam int DIFF_W = POS_W + 1;
   localparam int SQ_W   = 2 * POS_W;
   localparam int DIST_W = SQ_W + 1;
   localparam int PROD_W = TRIG_W + DIFF_W;
   localparam int ACC_W  = PROD_W + 1;
   localparam int BIAS_W = ACC_W + 1;
   localparam int RND_W  = BIAS_W - FRAC_TRIG;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_SCAN  = 7'b0000010,
      ST_SETUP = 7'b0000100,
      ST_EREAD = 7'b0001000,
      ST_EDATA = 7'b0010000,
      ST_EMUL  = 7'b0100000,
      ST_EOUT  = 7'b1000000
   } state_type;

   function automatic logic signed [POS_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
      logic signed [BIAS_W-1:0] biased;
      logic signed [RND_W-1:0]  r;
      logic signed [POS_W-1:0]  res;
      biased = {acc[ACC_W-1], acc} + BIAS_W'(1 << (FRAC_TRIG - 1));
      r      = biased[BIAS_W-1:FRAC_TRIG];
      if (r[RND_W-1:POS_W-1] == '0 || r[RND_W-1:POS_W-1] == '1) begin
         res = r[POS_W-1:0];
      end else if (r[RND_W-1]) begin
         res = {1'b1, {(POS_W-1){1'b0}}};
      end else begin
         res = {1'b0, {(POS_W-1){1'b1}}};
      end
      return res;
   endfunction

   // Configuration registers.
   logic [CNT_W-1:0] wcount_ff;
   logic [LA_W-1:0]  lookahead_ff;
   logic [CNT_W-1:0] count_eff;
   logic [LA_W-1:0]  ahead_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wcount_ff    <= '0;
         lookahead_ff <= LA_W'(LA_RESET);
      end else if (csr_write) begin
         case (csr_index)
            CSR_WAYPOINT_COUNT: wcount_ff    <= csr_data[CNT_W-1:0];
            CSR_LOOKAHEAD:      lookahead_ff <= csr_data[LA_W-1:0];
            default: ;
         endcase
      end
   end

   assign count_eff = (wcount_ff > CNT_W'(WP_DEPTH)) ? CNT_W'(WP_DEPTH) : wcount_ff;
   assign ahead_eff = (lookahead_ff > LA_W'(MAX_LOOKAHEAD)) ? LA_W'(MAX_LOOKAHEAD)
                                                           : lookahead_ff;

   // Control and pose state.
   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        scan_cnt_ff, scan_cnt_in;
   logic [IDX_W-1:0]        emit_idx_ff, emit_idx_in;
   logic [IDX_W-1:0]        end_ff, end_in;
   logic signed [POS_W-1:0] px_ff, py_ff;
   logic signed [TRIG_W-1:0] cos_ff, sin_ff;

   // Waypoint tables with a registered read port.
   logic [POS_W-1:0] wp_x_mem [WP_DEPTH];
   logic [POS_W-1:0] wp_y_mem [WP_DEPTH];
   logic             mem_we;
   logic [IDX_W-1:0] rd_addr;
   logic [POS_W-1:0] rd_x_ff, rd_y_ff;

   // Scan pipeline.
   logic                    issue;
   logic [3:0]              pv_ff;
   logic [IDX_W-1:0]        idx1_ff, idx2_ff, idx3_ff, idx4_ff;
   logic signed [DIFF_W-1:0] dx_s, dy_s;
   logic [POS_W-1:0]        ax_ff, ay_ff;
   logic [SQ_W-1:0]         sx_ff, sy_ff;
   logic [DIST_W-1:0]       dist_ff;
   logic [DIST_W-1:0]       best_dist_ff;
   logic [IDX_W-1:0]        best_ff;
   logic                    take_best;

   // Rotation path.
   logic signed [DIFF_W-1:0] dx_ff, dy_ff;
   logic signed [PROD_W-1:0] pcx_ff, psy_ff, pcy_ff, psx_ff;
   logic signed [ACC_W-1:0]  acc_x, acc_y;

   // Setup arithmetic.
   logic [CNT_W-1:0] last_pos;
   logic [CNT_W-1:0] reach;

   // Output register.
   logic                    out_free;
   logic                    out_load;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]        rsp_point_ff, rsp_nearest_ff;
   logic signed [POS_W-1:0] rsp_bx_ff, rsp_by_ff;
   logic                    rsp_last_ff;

   assign cmd_pop = (state_ff == ST_IDLE) && cmd_valid;
   assign mem_we  = cmd_pop && !cmd.is_pose;
   assign issue   = (state_ff == ST_SCAN) && (scan_cnt_ff < count_eff);
   assign rd_addr = (state_ff == ST_SCAN) ? scan_cnt_ff[IDX_W-1:0] : emit_idx_ff;

   assign last_pos = count_eff - 1'b1;
   assign reach    = CNT_W'(best_ff) + CNT_W'(ahead_eff);

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign out_load = (state_ff == ST_EOUT) && out_free;

   always_comb begin
      dx_s = DIFF_W'(signed'(rd_x_ff)) - DIFF_W'(px_ff);
      dy_s = DIFF_W'(signed'(rd_y_ff)) - DIFF_W'(py_ff);
      acc_x = ACC_W'(pcx_ff) + ACC_W'(psy_ff);
      acc_y = ACC_W'(pcy_ff) - ACC_W'(psx_ff);
      take_best = pv_ff[3] && ((idx4_ff == '0) || (dist_ff < best_dist_ff));
   end

   always_comb begin
      state_in    = state_ff;
      scan_cnt_in = scan_cnt_ff;
      emit_idx_in = emit_idx_ff;
      end_in      = end_ff;
      case (state_ff)
         ST_IDLE: begin
            scan_cnt_in = '0;
            if (cmd_pop && cmd.is_pose && count_eff != '0 && ahead_eff != '0) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               scan_cnt_in = scan_cnt_ff + 1'b1;
            end else if (pv_ff == '0) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            if (CNT_W'(best_ff) == last_pos) begin
               state_in = ST_IDLE;
            end else begin
               emit_idx_in = best_ff + 1'b1;
               end_in      = (reach > last_pos) ? last_pos[IDX_W-1:0] : reach[IDX_W-1:0];
               state_in    = ST_EREAD;
            end
         end
         ST_EREAD: state_in = ST_EDATA;
         ST_EDATA: state_in = ST_EMUL;
         ST_EMUL:  state_in = ST_EOUT;
         ST_EOUT: begin
            if (out_free) begin
               if (emit_idx_ff == end_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  emit_idx_in = emit_idx_ff + 1'b1;
                  state_in    = ST_EREAD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_cnt_ff  <= '0;
         pv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_cnt_ff  <= scan_cnt_in;
         pv_ff        <= {pv_ff[2:0], issue};
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         wp_x_mem[cmd.wp_index] <= cmd.pos_x;
         wp_y_mem[cmd.wp_index] <= cmd.pos_y;
      end
      rd_x_ff <= wp_x_mem[rd_addr];
      rd_y_ff <= wp_y_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      emit_idx_ff <= emit_idx_in;
      end_ff      <= end_in;
      if (cmd_pop && cmd.is_pose) begin
         px_ff  <= cmd.pos_x;
         py_ff  <= cmd.pos_y;
         cos_ff <= cmd.yaw_cos;
         sin_ff <= cmd.yaw_sin;
      end
      idx1_ff <= scan_cnt_ff[IDX_W-1:0];
      idx2_ff <= idx1_ff;
      idx3_ff <= idx2_ff;
      idx4_ff <= idx3_ff;
      ax_ff   <= dx_s[DIFF_W-1] ? POS_W'(-dx_s) : dx_s[POS_W-1:0];
      ay_ff   <= dy_s[DIFF_W-1] ? POS_W'(-dy_s) : dy_s[POS_W-1:0];
      sx_ff   <= SQ_W'(ax_ff) * SQ_W'(ax_ff);
      sy_ff   <= SQ_W'(ay_ff) * SQ_W'(ay_ff);
      dist_ff <= DIST_W'(sx_ff) + DIST_W'(sy_ff);
      if (take_best) begin
         best_ff      <= idx4_ff;
         best_dist_ff <= dist_ff;
      end
      dx_ff  <= dx_s;
      dy_ff  <= dy_s;
      pcx_ff <= PROD_W'(cos_ff) * PROD_W'(dx_ff);
      psy_ff <= PROD_W'(sin_ff) * PROD_W'(dy_ff);
      pcy_ff <= PROD_W'(cos_ff) * PROD_W'(dy_ff);
      psx_ff <= PROD_W'(sin_ff) * PROD_W'(dx_ff);
      if (out_load) begin
         rsp_point_ff   <= emit_idx_ff;
         rsp_nearest_ff <= best_ff;
         rsp_bx_ff      <= round_sat(acc_x);
         rsp_by_ff      <= round_sat(acc_y);
         rsp_last_ff    <= (emit_idx_ff == end_ff);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_point_index   = rsp_point_ff;
   assign rsp_nearest_index = rsp_nearest_ff;
   assign rsp_body_x        = rsp_bx_ff;
   assign rsp_body_y        = rsp_by_ff;
   assign rsp_last          = rsp_last_ff;

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register is not one-hot");

   a_scan_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SETUP |-> pv_ff == '0 && scan_cnt_ff == count_eff)
      else $error("emit setup entered before the scan drained");

   a_emit_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EOUT |-> emit_idx_ff > best_ff && emit_idx_ff <= end_ff)
      else $error("emitted index outside the lookahead window");

   a_result_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_point_ff > rsp_nearest_ff)
      else $error("result index does not follow the nearest waypoint");

endmodule

`default_nettype wire

// ----- tb/nwbf_checker.sv -----
// Checker for nearest_waypoint_body_frame: mirrors the waypoint tables and both registers,
// predicts the body-frame points of every pose item and compares the results in order.
// Depends on nwbf_pkg.
module nwbf_checker import nwbf_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_stall,
   input  wire logic                     req_opcode,
   input  wire logic [IDX_W-1:0]         req_wp_index,
   input  wire logic signed [POS_W-1:0]  req_pos_x,
   input  wire logic signed [POS_W-1:0]  req_pos_y,
   input  wire logic signed [TRIG_W-1:0] req_yaw_cos,
   input  wire logic signed [TRIG_W-1:0] req_yaw_sin,
   input  wire logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   input  wire logic [IDX_W-1:0]         rsp_point_index,
   input  wire logic [IDX_W-1:0]         rsp_nearest_index,
   input  wire logic signed [POS_W-1:0]  rsp_body_x,
   input  wire logic signed [POS_W-1:0]  rsp_body_y,
   input  wire logic                     rsp_last,
   input  wire logic                     csr_write,
   input  wire logic [CSR_IDX_W-1:0]     csr_index,
   input  wire logic [CSR_DATA_W-1:0]    csr_data,
   output int                            mismatches,
   output int                            points_outstanding
);

   localparam longint BODY_MAX = 64'sd2147483647;
   localparam longint BODY_MIN = -64'sd2147483648;

   typedef struct {
      logic [IDX_W-1:0]        point_index;
      logic [IDX_W-1:0]        nearest_index;
      logic signed [POS_W-1:0] body_x;
      logic signed [POS_W-1:0] body_y;
      logic                    last;
   } body_point_type;

   logic signed [POS_W-1:0] wp_x [WP_DEPTH];
   logic signed [POS_W-1:0] wp_y [WP_DEPTH];
   logic [CNT_W-1:0]        count_reg;
   logic [LA_W-1:0]         ahead_reg;
   body_point_type          expected_points[$];

   initial begin
      mismatches = 0;
      points_outstanding = 0;
   end

   function automatic logic [2*POS_W+2:0] range_sq(input logic signed [POS_W-1:0] wx, wy,
                                                   input logic signed [POS_W-1:0] px, py);
      logic signed [POS_W:0] dx, dy;
      logic [2*POS_W+2:0]    ax, ay;
      dx = $signed({wx[POS_W-1], wx}) - $signed({px[POS_W-1], px});
      dy = $signed({wy[POS_W-1], wy}) - $signed({py[POS_W-1], py});
      ax = dx[POS_W] ? -dx : dx;
      ay = dy[POS_W] ? -dy : dy;
      return ax * ax + ay * ay;
   endfunction

   // Rounds to nearest with ties upwards, then clamps to 32 bits.
   function automatic logic signed [POS_W-1:0] round_sat(input longint acc);
      longint r;
      r = (acc + (64'sd1 <<< (FRAC_TRIG - 1))) >>> FRAC_TRIG;
      if (r > BODY_MAX) r = BODY_MAX;
      if (r < BODY_MIN) r = BODY_MIN;
      return r[POS_W-1:0];
   endfunction

   task automatic predict_points(input logic signed [POS_W-1:0] px, py,
                                 input logic signed [TRIG_W-1:0] c, s);
      int                 n, ahead, best, stop, i;
      logic [2*POS_W+2:0] d, best_d;
      longint             dx, dy;
      body_point_type     p;
      n = (count_reg > WP_DEPTH) ? WP_DEPTH : count_reg;
      ahead = (ahead_reg > MAX_LOOKAHEAD) ? MAX_LOOKAHEAD : ahead_reg;
      if (n == 0 || ahead == 0) return;
      best = 0;
      best_d = range_sq(wp_x[0], wp_y[0], px, py);
      for (i = 1; i < n; i++) begin
         d = range_sq(wp_x[i], wp_y[i], px, py);
         if (d < best_d) begin
            best = i;
            best_d = d;
         end
      end
      stop = best + ahead;
      if (stop > n - 1) stop = n - 1;
      for (i = best + 1; i <= stop; i++) begin
         dx = longint'(wp_x[i]) - longint'(px);
         dy = longint'(wp_y[i]) - longint'(py);
         p.point_index = i[IDX_W-1:0];
         p.nearest_index = best[IDX_W-1:0];
         p.body_x = round_sat(longint'(c) * dx + longint'(s) * dy);
         p.body_y = round_sat(longint'(c) * dy - longint'(s) * dx);
         p.last = (i == stop);
         expected_points.insert(expected_points.size(), p);
      end
   endtask

   task automatic compare_field(input string field, input logic signed [63:0] want, got);
      if (got !== want) begin
         $display("%0t: %s expected %0d got %0d", $time, field, want, got);
         mismatches++;
      end
   endtask

   task automatic check_point();
      body_point_type want;
      if (expected_points.size() == 0) begin
         $display("%0t: point %0d arrived with nothing expected", $time, rsp_point_index);
         mismatches++;
         return;
      end
      want = expected_points.pop_front();
      compare_field("point_index", want.point_index, rsp_point_index);
      compare_field("nearest_index", want.nearest_index, rsp_nearest_index);
      compare_field("body_x", want.body_x, rsp_body_x);
      compare_field("body_y", want.body_y, rsp_body_y);
      compare_field("last", want.last, rsp_last);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         count_reg = '0;
         ahead_reg = LA_W'(LA_RESET);
         expected_points.delete();
      end else begin
         if (rsp_valid && !rsp_stall) check_point();
         if (csr_write) begin
            if (csr_index == CSR_WAYPOINT_COUNT) count_reg = csr_data;
            else if (csr_index == CSR_LOOKAHEAD) ahead_reg = csr_data[LA_W-1:0];
         end
         if (req_valid && !req_stall) begin
            if (req_opcode == OP_LOAD) begin
               wp_x[req_wp_index] = req_pos_x;
               wp_y[req_wp_index] = req_pos_y;
            end else begin
               predict_points(req_pos_x, req_pos_y, req_yaw_cos, req_yaw_sin);
            end
         end
      end
      points_outstanding <= expected_points.size();
   end

endmodule

// ----- tb/tb.sv -----
// Top of the nearest_waypoint_body_frame testbench: clock, reset, stimulus and verdict.
// Depends on nwbf_pkg, the block itself and nwbf_checker.
module tb;
   import nwbf_pkg::*;

   localparam int HALF_PERIOD    = 6;
   localparam int RESET_CYCLES   = 11;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES    = 300;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic                     req_opcode;
   logic [IDX_W-1:0]         req_wp_index;
   logic signed [POS_W-1:0]  req_pos_x;
   logic signed [POS_W-1:0]  req_pos_y;
   logic signed [TRIG_W-1:0] req_yaw_cos;
   logic signed [TRIG_W-1:0] req_yaw_sin;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [IDX_W-1:0]         rsp_point_index;
   logic [IDX_W-1:0]         rsp_nearest_index;
   logic signed [POS_W-1:0]  rsp_body_x;
   logic signed [POS_W-1:0]  rsp_body_y;
   logic                     rsp_last;
   logic                     csr_write;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [CSR_DATA_W-1:0]    csr_data;
   int                       mismatches;
   int                       points_outstanding;

   logic signed [POS_W-1:0]  path_x [WP_DEPTH];
   logic signed [POS_W-1:0]  path_y [WP_DEPTH];
   bit                       idle_on;
   bit                       sender_gaps;
   int                       active_count;
   int                       hold_requests;
   int                       holds_started = 0;
   int                       hold_left = 0;
   int                       burst_left = 0;
   int                       run_left = 0;
   int                       quiet_cycles = 0;

   nearest_waypoint_body_frame dut (.*);
   nwbf_checker checker_i (.*);

   always #HALF_PERIOD clock = ~clock;

   always @(negedge clock) begin
      if (hold_left == 0 && holds_started != hold_requests) begin
         holds_started = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!idle_on) begin
         rsp_stall <= 1'b0;
      end else if (burst_left > 0) begin
         burst_left--;
         rsp_stall <= 1'b1;
      end else if (run_left > 0) begin
         run_left--;
         rsp_stall <= 1'b0;
      end else begin
         burst_left = $urandom_range(1, 12) - 1;
         run_left = $urandom_range(0, 40);
         rsp_stall <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("nearest_waypoint_body_frame: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic signed [TRIG_W-1:0] rand_trig();
      case ($urandom_range(0, 9))
         0: return TRIG_W'(16384);
         1: return TRIG_W'(-16384);
         default: return TRIG_W'($urandom_range(0, 32768) - 16384);
      endcase
   endfunction

   task automatic send_item(input logic op, input logic [IDX_W-1:0] idx,
                            input logic signed [POS_W-1:0] x, y,
                            input logic signed [TRIG_W-1:0] c, s);
      if (idle_on && sender_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_wp_index <= idx;
      req_pos_x <= x;
      req_pos_y <= y;
      req_yaw_cos <= c;
      req_yaw_sin <= s;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic load_point(input int k, input logic signed [POS_W-1:0] x, y);
      path_x[k] = x;
      path_y[k] = y;
      send_item(OP_LOAD, k[IDX_W-1:0], x, y, rand_trig(), rand_trig());
   endtask

   task automatic send_pose(input logic signed [POS_W-1:0] x, y,
                            input logic signed [TRIG_W-1:0] c, s);
      send_item(OP_POSE, IDX_W'($urandom_range(0, WP_DEPTH - 1)), x, y, c, s);
   endtask

   // Waits until the block has nothing left to give, then lets it finish any
   // item that gives no result.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (points_outstanding != 0) @(negedge clock);
      repeat (5 * (active_count + 16)) @(negedge clock);
   endtask

   task automatic set_limits(input int count, input int ahead);
      csr_write <= 1'b1;
      csr_index <= CSR_WAYPOINT_COUNT;
      csr_data <= count[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_index <= CSR_LOOKAHEAD;
      csr_data <= ahead[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_write <= 1'b0;
      active_count = (count > WP_DEPTH) ? WP_DEPTH : count;
   endtask

   // A wandering path with the odd jump anywhere and the odd repeated point.
   task automatic build_path(input int n);
      logic signed [POS_W-1:0] x, y;
      int                      k;
      x = $signed($urandom_range(0, 2097151)) - 1048576;
      y = $signed($urandom_range(0, 2097151)) - 1048576;
      for (k = 0; k < n; k++) begin
         case ($urandom_range(0, 11))
            0: begin
               x = $urandom();
               y = $urandom();
            end
            1: ;
            default: begin
               x += $signed($urandom_range(0, 8191)) - 4096;
               y += $signed($urandom_range(0, 8191)) - 4096;
            end
         endcase
         load_point(k, x, y);
      end
   endtask

   task automatic random_pose();
      int k;
      k = $urandom_range(0, active_count - 1);
      case ($urandom_range(0, 9))
         0, 1: send_pose($urandom(), $urandom(), rand_trig(), rand_trig());
         2: send_pose(path_x[k], path_y[k], rand_trig(), rand_trig());
         3: send_pose(path_x[active_count - 1], path_y[active_count - 1],
                      rand_trig(), rand_trig());
         default: send_pose(path_x[k] + $signed($urandom_range(0, 4095)) - 2048,
                            path_y[k] + $signed($urandom_range(0, 4095)) - 2048,
                            rand_trig(), rand_trig());
      endcase
   endtask

   task automatic random_phase(input int count, input int ahead, input int poses,
                               input bit hold);
      int j, k;
      wait_idle();
      set_limits(count, ahead);
      build_path(count);
      if (hold) hold_requests++;
      for (j = 0; j < poses; j++) begin
         if ($urandom_range(0, 5) == 0) begin
            if ($urandom_range(0, 1) == 0) begin
               load_point($urandom_range(count, WP_DEPTH - 1), $urandom(), $urandom());
            end else begin
               k = $urandom_range(0, count - 1);
               load_point(k, path_x[k] + $signed($urandom_range(0, 255)) - 128,
                          path_y[k] + $signed($urandom_range(0, 255)) - 128);
            end
         end
         random_pose();
      end
   endtask

   function automatic int pick_ahead();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return MAX_LOOKAHEAD;
         2: return $urandom_range(MAX_LOOKAHEAD + 1, 127);
         3: return $urandom_range(17, MAX_LOOKAHEAD - 1);
         default: return $urandom_range(1, 16);
      endcase
   endfunction

   initial begin
      int ph;
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_LOAD;
      req_wp_index = '0;
      req_pos_x = '0;
      req_pos_y = '0;
      req_yaw_cos = '0;
      req_yaw_sin = '0;
      rsp_stall = 1'b0;
      csr_write = 1'b0;
      csr_index = CSR_WAYPOINT_COUNT;
      csr_data = '0;
      idle_on = 1'b1;
      sender_gaps = 1'b1;
      hold_requests = 0;
      active_count = 0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // The table is empty straight after reset.
      send_pose(0, 0, 16384, 0);
      load_point(0, 0, 0);
      load_point(1, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
      load_point(2, 32'sh80000000, 32'sh80000000);
      load_point(3, 32'sh7FFFFFFF, 32'sh80000000);
      load_point(4, 256, -256);
      load_point(5, 0, 0);
      load_point(6, 32'sh80000000, 32'sh7FFFFFFF);
      load_point(7, 1000, 2000);
      load_point(8, -1, 1);
      load_point(9, 5000, -7000);
      wait_idle();
      set_limits(10, 1);
      send_pose(0, 0, 16384, 0);
      send_pose(32'sh80000000, 32'sh80000000, 16384, 16384);
      send_pose(32'sh7FFFFFFF, 32'sh7FFFFFFF, -16384, -16384);
      wait_idle();
      set_limits(10, 0);
      send_pose(1000, 2000, 16384, 0);
      wait_idle();
      set_limits(10, 127);
      send_pose(5000, -7000, 0, 16384);
      send_pose(1000 - 8192, 2000, 1, -1);
      send_pose(-1, -1, 16384, -16384);
      wait_idle();
      set_limits(1, MAX_LOOKAHEAD);
      send_pose(100, 100, 16384, 0);
      wait_idle();
      set_limits(0, MAX_LOOKAHEAD);
      send_pose(0, 0, 16384, 0);

      for (ph = 0; ph < 12; ph++) begin
         if (ph == 10) idle_on = 1'b0;
         sender_gaps = ($urandom_range(0, 3) != 0);
         if (ph == 4)
            random_phase(40, 20, 14, 1'b1);
         else
            random_phase((ph % 3 == 0) ? $urandom_range(2, 6) : $urandom_range(7, 36),
                         pick_ahead(), $urandom_range(6, 14), 1'b0);
      end
      wait_idle();

      if (mismatches == 0 && points_outstanding == 0)
         $display("nearest_waypoint_body_frame: match");
      else
         $display("nearest_waypoint_body_frame: mismatch");
      $finish;
   end

endmodule
